### src/krenc_pkg.sv
// ----------------------------------------------------------------------------
// krenc_pkg
// Shared constants for the keyboard report encoder: key code ranges, boot
// report slot count, byte index width.
// ----------------------------------------------------------------------------
package krenc_pkg;

  localparam int unsigned BITMAP_BYTES_DEF = 32;
  localparam int unsigned SLOT_COUNT       = 6;
  localparam int unsigned FILL_W           = 3;
  localparam int unsigned IDX_W            = 6;

  localparam logic [15:0] CODE_NONE      = 16'h0000;
  localparam logic [15:0] CODE_MOD_FIRST = 16'h00E0;
  localparam logic [15:0] CODE_MOD_LAST  = 16'h00E7;

  localparam logic [IDX_W-1:0] BOOT_LAST_IDX = 6'd7;

  typedef enum logic {
    KIND_BOOT   = 1'b0,
    KIND_BITMAP = 1'b1
  } report_kind_t;

endpackage

### src/krenc_collect.sv
// ----------------------------------------------------------------------------
// krenc_collect
// Gathers one scan: modifier bits, six boot slots and the key bitmap. Gives
// the state including the current transaction's key, and clears at scan end.
// ----------------------------------------------------------------------------
module krenc_collect
  import krenc_pkg::*;
#(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic [15:0]                      key_code,
  input  logic                             end_of_scan,
  output logic [7:0]                       upd_mods,
  output logic [SLOT_COUNT-1:0][7:0]       upd_slots,
  output logic [BITMAP_BYTES-1:0][7:0]     upd_map
);

  localparam int unsigned MAP_AW = $clog2(BITMAP_BYTES);

  logic [7:0]                   mods;
  logic [SLOT_COUNT-1:0][7:0]   slots;
  logic [FILL_W-1:0]            fill;
  logic [BITMAP_BYTES-1:0][7:0] map;

  logic [FILL_W-1:0] fill_next;
  logic              is_mod;
  logic              is_key;

  assign is_mod = (key_code >= CODE_MOD_FIRST) && (key_code <= CODE_MOD_LAST);
  assign is_key = !is_mod && (key_code != CODE_NONE) && (key_code <= CODE_MOD_LAST);

  always_comb begin
    upd_mods  = mods;
    upd_slots = slots;
    upd_map   = map;
    fill_next = fill;
    if (is_mod) begin
      upd_mods[key_code[2:0]] = 1'b1;
    end
    if (is_key) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (fill == FILL_W'(i)) begin
          upd_slots[i] = key_code[7:0];
        end
      end
      if (fill < FILL_W'(SLOT_COUNT)) begin
        fill_next = fill + 1'b1;
      end
      for (int b = 0; b < BITMAP_BYTES; b++) begin
        if (key_code[7:3] == 5'(b)) begin
          upd_map[b][key_code[2:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_scan)) begin
      mods  <= '0;
      slots <= '0;
      fill  <= '0;
      map   <= '0;
    end else if (take) begin
      mods  <= upd_mods;
      slots <= upd_slots;
      fill  <= fill_next;
      map   <= upd_map;
    end
  end

  // bitmap index range check
  if (MAP_AW > 5) begin : g_aw_bad
    $error("BITMAP_BYTES out of range");
  end

endmodule

### src/keyboard_report_encoder.sv
// ----------------------------------------------------------------------------
// keyboard_report_encoder
// Builds six-key boot or full-bitmap keyboard reports from scanned key codes
// and sends a report as a byte stream only when it changed.
// ----------------------------------------------------------------------------
// Usage:
//   Key channel: key_code/end_of_scan with key_valid/key_stall. One key code
//   is taken per unstalled cycle; end_of_scan marks the last code of a scan.
//   Report channel: report_byte/byte_index/report_kind/final_byte with
//   report_valid/report_stall, one byte per transaction.
//   nkro_mode is written through nkro_mode_wr_en/nkro_mode_wr_data. The user
//   must write it only while idle; the block itself does not enforce this.
//   After an end_of_scan transaction sets busy, the first report byte is
//   loaded into the output register; bytes then follow one per cycle as long
//   as the receiver does not stall. A boot report is 8 bytes, a bitmap report
//   BITMAP_BYTES+2. key_stall is high from a scan end that sends a report
//   until its final byte is loaded, and a stalled output byte lengthens it.
//   Other key codes raise no stall. A report equal to the last report sent,
//   when that was of the same kind, produces no bytes and no stall.
//   Reset clears the scan state, the stored last reports and selects boot
//   mode. A stalled output byte is held; the drain counter waits behind it.
// ----------------------------------------------------------------------------
module keyboard_report_encoder
  import krenc_pkg::*;
#(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              nkro_mode_wr_en,
  input  logic              nkro_mode_wr_data,
  input  logic              key_valid,
  output logic              key_stall,
  input  logic [15:0]       key_code,
  input  logic              end_of_scan,
  output logic              report_valid,
  input  logic              report_stall,
  output logic [7:0]        report_byte,
  output logic [IDX_W-1:0]  byte_index,
  output logic              report_kind,
  output logic              final_byte
);

  localparam int unsigned MAP_AW = $clog2(BITMAP_BYTES);
  localparam logic [IDX_W-1:0] MAP_LAST_IDX = IDX_W'(BITMAP_BYTES + 1);

  logic                         nkro_mode;
  logic                         take;
  logic                         scan_end;

  logic [7:0]                   upd_mods;
  logic [SLOT_COUNT-1:0][7:0]   upd_slots;
  logic [BITMAP_BYTES-1:0][7:0] upd_map;

  logic [7:0]                   sent_boot_mods;
  logic [SLOT_COUNT-1:0][7:0]   sent_boot_slots;
  logic [7:0]                   sent_map_mods;
  logic [BITMAP_BYTES-1:0][7:0] sent_map;
  logic                         sent_was_bitmap;

  logic                         busy;
  report_kind_t                 kind;
  logic [IDX_W-1:0]             idx;

  logic                         boot_diff;
  logic                         map_diff;
  logic                         load;
  logic [IDX_W-1:0]             last_idx;
  logic [IDX_W-1:0]             sel;
  logic [7:0]                   byte_mux;

  assign key_stall = busy;
  assign take      = key_valid && !key_stall;
  assign scan_end  = take && end_of_scan;

  krenc_collect #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_collect (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .key_code   (key_code),
    .end_of_scan(end_of_scan),
    .upd_mods   (upd_mods),
    .upd_slots  (upd_slots),
    .upd_map    (upd_map)
  );

  assign map_diff  = !sent_was_bitmap || (upd_mods != sent_map_mods) || (upd_map != sent_map);
  assign boot_diff = sent_was_bitmap || (upd_mods != sent_boot_mods)
                     || (upd_slots != sent_boot_slots);

  assign load     = busy && (!report_valid || !report_stall);
  assign last_idx = (kind == KIND_BITMAP) ? MAP_LAST_IDX : BOOT_LAST_IDX;
  assign sel      = idx - IDX_W'(2);

  always_comb begin
    byte_mux = '0;
    if (idx == IDX_W'(0)) begin
      byte_mux = (kind == KIND_BITMAP) ? sent_map_mods : sent_boot_mods;
    end else if (idx != IDX_W'(1)) begin
      if (kind == KIND_BITMAP) begin
        byte_mux = sent_map[sel[MAP_AW-1:0]];
      end else begin
        byte_mux = sent_boot_slots[sel[2:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nkro_mode       <= 1'b0;
      sent_boot_mods  <= '0;
      sent_boot_slots <= '0;
      sent_map_mods   <= '0;
      sent_map        <= '0;
      sent_was_bitmap <= 1'b0;
      busy            <= 1'b0;
      kind            <= KIND_BOOT;
      idx             <= '0;
      report_valid    <= 1'b0;
    end else begin
      if (nkro_mode_wr_en) begin
        nkro_mode <= nkro_mode_wr_data;
      end
      if (scan_end) begin
        if (nkro_mode && map_diff) begin
          sent_map_mods   <= upd_mods;
          sent_map        <= upd_map;
          sent_was_bitmap <= 1'b1;
          busy            <= 1'b1;
          kind            <= KIND_BITMAP;
          idx             <= '0;
        end else if (!nkro_mode && boot_diff) begin
          sent_boot_mods  <= upd_mods;
          sent_boot_slots <= upd_slots;
          sent_was_bitmap <= 1'b0;
          busy            <= 1'b1;
          kind            <= KIND_BOOT;
          idx             <= '0;
        end
      end
      if (load) begin
        report_valid <= 1'b1;
        report_byte  <= byte_mux;
        byte_index   <= idx;
        report_kind  <= kind;
        final_byte   <= (idx == last_idx);
        if (idx == last_idx) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (report_valid && !report_stall) begin
        report_valid <= 1'b0;
      end
    end
  end

  a_next_byte: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report_stall && !final_byte)
      |=> (report_valid && (byte_index == $past(byte_index) + IDX_W'(1))))
    else $error("report bytes not contiguous");

  a_final_idx: assert property (@(posedge clk) disable iff (rst)
    (report_valid && final_byte)
      |-> (byte_index == (report_kind ? MAP_LAST_IDX : BOOT_LAST_IDX)))
    else $error("final byte at wrong position");

  a_no_scan_drain: assert property (@(posedge clk) disable iff (rst)
    scan_end |-> !load)
    else $error("scan end taken while draining");

endmodule

### tb/sv/keyboard_report_encoder_checker.sv
// ----------------------------------------------------------------------------
// keyboard_report_encoder_checker
// Watches the key, report and mode-write ports of the keyboard report encoder.
// Rebuilds the boot and bitmap reports from each accepted key transaction,
// queues the bytes that a scan end must send, and compares every accepted
// report byte with the oldest queued one.
// ----------------------------------------------------------------------------
module keyboard_report_encoder_checker
  import krenc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             nkro_mode_wr_en,
  input  logic             nkro_mode_wr_data,
  input  logic             key_valid,
  input  logic             key_stall,
  input  logic [15:0]      key_code,
  input  logic             end_of_scan,
  input  logic             report_valid,
  input  logic             report_stall,
  input  logic [7:0]       report_byte,
  input  logic [IDX_W-1:0] byte_index,
  input  logic             report_kind,
  input  logic             final_byte,
  output int               mismatches,
  output int               outstanding,
  output int               bytes_checked
);

  localparam int unsigned BOOT_LEN = 8;
  localparam int unsigned BMAP_LEN = BITMAP_BYTES_DEF + 2;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    report_kind_t     kind;
    logic             is_final;
  } report_beat_t;

  logic         nkro_sel;
  logic [7:0]   scan_mods;
  logic [7:0]   scan_slots [SLOT_COUNT];
  int unsigned  scan_fill;
  logic [7:0]   scan_bitmap [BITMAP_BYTES_DEF];
  logic [7:0]   last_boot [BOOT_LEN];
  logic [7:0]   last_bitmap [BMAP_LEN];
  logic         last_was_bitmap;
  report_beat_t pending_bytes [$];
  int           err_count = 0;
  int           byte_count = 0;

  task automatic clear_scan();
    scan_mods = 8'h00;
    scan_fill = 0;
    foreach (scan_slots[i]) scan_slots[i] = 8'h00;
    foreach (scan_bitmap[i]) scan_bitmap[i] = 8'h00;
  endtask

  task automatic reset_predictor();
    nkro_sel = 1'b0;
    clear_scan();
    foreach (last_boot[i]) last_boot[i] = 8'h00;
    foreach (last_bitmap[i]) last_bitmap[i] = 8'h00;
    last_was_bitmap = 1'b0;
    pending_bytes.delete();
  endtask

  task automatic absorb_key(input logic [15:0] code, input logic eos);
    logic [7:0]   rep [BMAP_LEN];
    int unsigned  len;
    bit           changed;
    report_kind_t kind;
    if (code >= CODE_MOD_FIRST && code <= CODE_MOD_LAST) begin
      scan_mods[code[2:0]] = 1'b1;
    end else if (code != CODE_NONE && code < CODE_MOD_FIRST) begin
      if (scan_fill < SLOT_COUNT) begin
        scan_slots[scan_fill] = code[7:0];
        scan_fill++;
      end
      if (code[15:3] < BITMAP_BYTES_DEF) scan_bitmap[code[15:3]][code[2:0]] = 1'b1;
    end
    if (!eos) return;

    foreach (rep[i]) rep[i] = 8'h00;
    rep[0] = scan_mods;
    if (nkro_sel) begin
      kind = KIND_BITMAP;
      len = BMAP_LEN;
      for (int i = 0; i < BITMAP_BYTES_DEF; i++) rep[i + 2] = scan_bitmap[i];
      changed = !last_was_bitmap;
      for (int i = 0; i < BMAP_LEN; i++) if (rep[i] != last_bitmap[i]) changed = 1'b1;
      if (changed) begin
        for (int i = 0; i < BMAP_LEN; i++) last_bitmap[i] = rep[i];
        last_was_bitmap = 1'b1;
      end
    end else begin
      kind = KIND_BOOT;
      len = BOOT_LEN;
      for (int i = 0; i < SLOT_COUNT; i++) rep[i + 2] = scan_slots[i];
      changed = last_was_bitmap;
      for (int i = 0; i < BOOT_LEN; i++) if (rep[i] != last_boot[i]) changed = 1'b1;
      if (changed) begin
        for (int i = 0; i < BOOT_LEN; i++) last_boot[i] = rep[i];
        last_was_bitmap = 1'b0;
      end
    end
    if (changed) begin
      for (int i = 0; i < len; i++) begin
        pending_bytes.push_back('{data: rep[i], index: IDX_W'(i), kind: kind,
                                  is_final: (i == len - 1)});
      end
    end
    clear_scan();
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: report %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    report_beat_t exp_b;
    if (rst) begin
      reset_predictor();
    end else begin
      if (nkro_mode_wr_en) nkro_sel = nkro_mode_wr_data;
      if (report_valid && !report_stall) begin
        byte_count++;
        if (pending_bytes.size() == 0) begin
          err_count++;
          $display("%0t: unexpected report byte: expected none, actual %0h idx %0d kind %0d fin %0d",
                   $time, report_byte, byte_index, report_kind, final_byte);
        end else begin
          exp_b = pending_bytes.pop_front();
          check_field("byte", exp_b.data, report_byte);
          check_field("index", {2'b00, exp_b.index}, {2'b00, byte_index});
          check_field("kind", {7'd0, exp_b.kind}, {7'd0, report_kind});
          check_field("final flag", {7'd0, exp_b.is_final}, {7'd0, final_byte});
        end
      end
      if (key_valid && !key_stall) absorb_key(key_code, end_of_scan);
    end
    mismatches    <= err_count;
    outstanding   <= pending_bytes.size();
    bytes_checked <= byte_count;
  end

endmodule

### tb/sv/keyboard_report_encoder_tb.sv
// ----------------------------------------------------------------------------
// keyboard_report_encoder_tb
// Drives key scans into the keyboard report encoder in both report modes:
// a directed set of scans for modifiers, slot overflow, repeated and ignored
// codes, unchanged reports and a mode change inside a scan, then random scans
// with random idling on both channels. The checker module predicts and
// compares the report bytes; this module gives the verdict.
// ----------------------------------------------------------------------------
module keyboard_report_encoder_tb;
  import krenc_pkg::*;

  localparam int unsigned TOTAL_ITEMS  = 500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned CFG_SETTLE   = 8;
  localparam int unsigned DRAIN_SETTLE = 48;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             nkro_mode_wr_en = 1'b0;
  logic             nkro_mode_wr_data = 1'b0;
  logic             key_valid = 1'b0;
  logic             key_stall;
  logic [15:0]      key_code = CODE_NONE;
  logic             end_of_scan = 1'b0;
  logic             report_valid;
  logic             report_stall = 1'b0;
  logic [7:0]       report_byte;
  logic [IDX_W-1:0] byte_index;
  logic             report_kind;
  logic             final_byte;

  int               mismatches;
  int               outstanding;
  int               bytes_checked;
  int unsigned      cycle_count = 0;
  int unsigned      items_sent = 0;
  int unsigned      scans_sent = 0;
  int unsigned      mode_writes = 0;
  logic             quiet = 1'b0;

  keyboard_report_encoder i_dut (
    .clk               (clk),
    .rst               (rst),
    .nkro_mode_wr_en   (nkro_mode_wr_en),
    .nkro_mode_wr_data (nkro_mode_wr_data),
    .key_valid         (key_valid),
    .key_stall         (key_stall),
    .key_code          (key_code),
    .end_of_scan       (end_of_scan),
    .report_valid      (report_valid),
    .report_stall      (report_stall),
    .report_byte       (report_byte),
    .byte_index        (byte_index),
    .report_kind       (report_kind),
    .final_byte        (final_byte)
  );

  keyboard_report_encoder_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .nkro_mode_wr_en   (nkro_mode_wr_en),
    .nkro_mode_wr_data (nkro_mode_wr_data),
    .key_valid         (key_valid),
    .key_stall         (key_stall),
    .key_code          (key_code),
    .end_of_scan       (end_of_scan),
    .report_valid      (report_valid),
    .report_stall      (report_stall),
    .report_byte       (report_byte),
    .byte_index        (byte_index),
    .report_kind       (report_kind),
    .final_byte        (final_byte),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .bytes_checked     (bytes_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      report_stall <= 1'b0;
    end else begin
      report_stall <= !quiet && ($urandom_range(0, 99) < 13);
    end
  end

  task automatic send_key(input logic [15:0] code, input logic eos);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      key_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    key_valid   <= 1'b1;
    key_code    <= code;
    end_of_scan <= eos;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    items_sent++;
    if (eos) scans_sent++;
  endtask

  // mode writes only once every queued report byte has drained
  task automatic set_mode(input logic m);
    key_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    nkro_mode_wr_en   <= 1'b1;
    nkro_mode_wr_data <= m;
    @(posedge clk);
    nkro_mode_wr_en <= 1'b0;
    mode_writes++;
  endtask

  initial begin : stimulus
    logic [15:0] scan_codes [$];
    logic [15:0] prev_scan [$];
    logic [15:0] c;
    int unsigned n;
    int unsigned sel;
    int unsigned next_switch;
    logic        cur_mode;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // boot mode: modifiers at both ends of the range
    send_key(CODE_MOD_FIRST, 1'b0);
    send_key(16'h0004, 1'b0);
    send_key(CODE_MOD_LAST, 1'b1);
    // repeated key, ignored codes, seventh regular key dropped
    send_key(16'h0001, 1'b0);
    send_key(16'h0002, 1'b0);
    send_key(CODE_NONE, 1'b0);
    send_key(16'h0003, 1'b0);
    send_key(16'h0003, 1'b0);
    send_key(16'h00E8, 1'b0);
    send_key(16'h00DF, 1'b0);
    send_key(16'hFFFF, 1'b0);
    send_key(16'h0005, 1'b0);
    send_key(16'h0006, 1'b1);
    // empty report, then the same one unchanged
    send_key(CODE_NONE, 1'b1);
    send_key(CODE_NONE, 1'b1);

    // bitmap mode: first report always sent after a kind change
    set_mode(1'b1);
    send_key(CODE_NONE, 1'b1);
    send_key(16'h0001, 1'b0);
    send_key(16'h00DF, 1'b0);
    send_key(16'h00E5, 1'b1);
    send_key(16'h0001, 1'b0);
    send_key(16'h00DF, 1'b0);
    send_key(16'h00E5, 1'b1);

    // mode change inside a scan
    send_key(16'h0010, 1'b0);
    set_mode(1'b0);
    send_key(16'h0011, 1'b1);
    set_mode(1'b1);
    send_key(16'h002A, 1'b1);

    cur_mode = 1'b1;
    next_switch = items_sent + $urandom_range(30, 70);
    while (items_sent < TOTAL_ITEMS) begin
      quiet <= (items_sent >= 200 && items_sent < 320);
      if (items_sent >= next_switch) begin
        cur_mode = !cur_mode;
        set_mode(cur_mode);
        next_switch = items_sent + $urandom_range(30, 70);
      end
      scan_codes.delete();
      if (prev_scan.size() != 0 && $urandom_range(0, 3) == 0) begin
        scan_codes = prev_scan;
      end else begin
        n = $urandom_range(1, 9);
        repeat (n) begin
          sel = $urandom_range(0, 99);
          if (sel < 45) c = 16'($urandom_range(1, 12));
          else if (sel < 70) c = 16'($urandom_range(1, CODE_MOD_FIRST - 1));
          else if (sel < 85) c = 16'($urandom_range(CODE_MOD_FIRST, CODE_MOD_LAST));
          else if (sel < 90) c = CODE_NONE;
          else c = 16'($urandom_range(CODE_MOD_LAST + 1, 16'hFFFF));
          scan_codes.push_back(c);
        end
      end
      foreach (scan_codes[i]) begin
        send_key(scan_codes[i], i == scan_codes.size() - 1);
        if (i == 0 && scan_codes.size() > 1 && $urandom_range(0, 19) == 0) begin
          cur_mode = !cur_mode;
          set_mode(cur_mode);
        end
      end
      prev_scan = scan_codes;
    end
    key_valid <= 1'b0;
    quiet <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);

    $display("Sent %0d key transactions in %0d scans over %0d mode writes",
             items_sent, scans_sent, mode_writes);
    $display("Checked %0d report bytes, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/krenc_pkg.sv
src/krenc_collect.sv
src/keyboard_report_encoder.sv
tb/sv/keyboard_report_encoder_checker.sv
tb/sv/keyboard_report_encoder_tb.sv
